// ----- rtl/core/slr_pkg.sv -----
// ----------------------------------------------------------------------------
// slr_pkg: shared types and constants for the servo linear ramp
// Word formats, operation and register codes, sequencer states, divider
// interface and fixed constants.
// ----------------------------------------------------------------------------
package slr_pkg;

   localparam int TIME_BITS = 32;

   localparam int PULSE_BITS = 16;
   localparam int ANGLE_BITS = 8;
   localparam int SPAN_BITS  = 16;
   localparam int NOW_BITS   = 32;

   // divider: unsigned magnitude in, signed quotient out
   localparam int DIV_NUM_BITS      = 32;
   localparam int DIV_DEN_BITS      = 16;
   localparam int DIV_BITS_PER_STEP = 2;
   localparam int DIV_STEPS         = DIV_NUM_BITS / DIV_BITS_PER_STEP;
   localparam int DIV_CNT_BITS      = $clog2(DIV_STEPS);
   localparam int QUOT_BITS         = DIV_DEN_BITS + 1;

   localparam logic [ANGLE_BITS-1:0] FULL_ANGLE    = 8'd180;
   localparam logic [PULSE_BITS-1:0] MIN_PULSE_RST = 16'd500;
   localparam logic [PULSE_BITS-1:0] MAX_PULSE_RST = 16'd2500;
   localparam logic [ANGLE_BITS-1:0] START_ANG_RST = 8'd90;

   localparam logic [1:0] OP_MOVE   = 2'd0;
   localparam logic [1:0] OP_WAIT   = 2'd1;
   localparam logic [1:0] OP_UPDATE = 2'd2;

   localparam logic [1:0] CSR_MIN_PULSE   = 2'd0;
   localparam logic [1:0] CSR_MAX_PULSE   = 2'd1;
   localparam logic [1:0] CSR_START_ANGLE = 2'd2;

   typedef struct packed {
      logic [1:0]            operation;
      logic [NOW_BITS-1:0]   now_ms;
      logic [ANGLE_BITS-1:0] target_angle;
      logic [SPAN_BITS-1:0]  duration_ms;
   } req_word_type;

   typedef struct packed {
      logic                  pulse_valid;
      logic [PULSE_BITS-1:0] pulse_us;
      logic                  done_res;
      logic [ANGLE_BITS-1:0] angle_now;
   } rsp_word_type;

   typedef struct packed {
      logic                    start;
      logic                    negate;
      logic [DIV_NUM_BITS-1:0] dividend;
      logic [DIV_DEN_BITS-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [QUOT_BITS-1:0] quotient;
   } div_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_P0_MUL,
      ST_P0_DIV,
      ST_P1_MUL,
      ST_P1_DIV,
      ST_D_MUL,
      ST_D_DIV,
      ST_FIN
   } state_type;

endpackage

// ----- rtl/core/slr_div.sv -----
// ----------------------------------------------------------------------------
// slr_div: iterative restoring divider
// Two quotient bits per cycle, unsigned magnitude, sign applied at the end.
// Quotient magnitude must fit the divisor width.
// ----------------------------------------------------------------------------
module slr_div (
   input  logic                clock,
   input  logic                reset,
   input  slr_pkg::div_req_type div_req,
   output slr_pkg::div_rsp_type div_rsp
);

   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic [slr_pkg::DIV_CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [slr_pkg::DIV_NUM_BITS-1:0]   num_ff, num_in;
   logic [slr_pkg::DIV_DEN_BITS-1:0]   rem_ff, rem_in;
   logic [slr_pkg::DIV_DEN_BITS-1:0]   den_ff, den_in;
   logic                               neg_ff, neg_in;
   logic [slr_pkg::DIV_NUM_BITS-1:0]   num_v;
   logic [slr_pkg::DIV_DEN_BITS-1:0]   rem_v;
   logic [slr_pkg::DIV_DEN_BITS:0]     trial;
   logic [slr_pkg::QUOT_BITS-1:0]      mag;

   always_comb begin
      num_v = num_ff;
      rem_v = rem_ff;
      for (int i = 0; i < slr_pkg::DIV_BITS_PER_STEP; i++) begin
         trial = {rem_v, num_v[slr_pkg::DIV_NUM_BITS-1]};
         if (trial >= {1'b0, den_ff}) begin
            trial = trial - {1'b0, den_ff};
            num_v = {num_v[slr_pkg::DIV_NUM_BITS-2:0], 1'b1};
         end else begin
            num_v = {num_v[slr_pkg::DIV_NUM_BITS-2:0], 1'b0};
         end
         rem_v = trial[slr_pkg::DIV_DEN_BITS-1:0];
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = div_req.dividend;
         rem_in  = '0;
         den_in  = div_req.divisor;
         neg_in  = div_req.negate;
      end else if (busy_ff) begin
         num_in = num_v;
         rem_in = rem_v;
         if (cnt_ff == slr_pkg::DIV_CNT_BITS'(slr_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign mag = {1'b0, num_ff[slr_pkg::DIV_DEN_BITS-1:0]};
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = neg_ff ? (~mag + 1'b1) : mag;

endmodule

// ----- rtl/core/servo_linear_ramp_top.sv -----
// ----------------------------------------------------------------------------
// servo_linear_ramp_top: time based linear pulse ramp for a hobby servo
// Move and wait commands answer at once; an update inside a running ramp
// goes through a shared multiplier and a shared two bit per cycle divider.
// Answers: commands, finished periods and held waits answer in the cycle
//   after acceptance. A ramp update runs three multiply/divide passes
//   (start pulse, goal pulse, interpolation), each a multiply state and
//   then a divide state that waits on the 16 iteration divider, and then
//   goes into the output register once it is free; a zero span skips the
//   last pass.
// Throughput: one word at a time; the input stalls while an update computes.
// Reset: synchronous, active high; registers to 500/2500 us, angle 90.
// ----------------------------------------------------------------------------
module servo_linear_ramp_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  slr_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output slr_pkg::rsp_word_type rsp_word,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [15:0]           csr_wdata
);

   // configuration and ramp state
   logic [slr_pkg::PULSE_BITS-1:0] min_ff, min_in;
   logic [slr_pkg::PULSE_BITS-1:0] max_ff, max_in;
   logic [slr_pkg::ANGLE_BITS-1:0] cur_ff, cur_in;
   logic [slr_pkg::ANGLE_BITS-1:0] goal_ff, goal_in;
   logic [slr_pkg::TIME_BITS-1:0]  start_time_ff, start_time_in;
   logic [slr_pkg::SPAN_BITS-1:0]  span_ff, span_in;
   logic                           waiting_ff, waiting_in;
   slr_pkg::state_type             state_ff, state_in;

   // working registers for one update
   logic [slr_pkg::SPAN_BITS-1:0]    prog_ff, prog_in;
   logic [slr_pkg::PULSE_BITS-1:0]   mul_mag_ff, mul_mag_in;
   logic                             mul_neg_ff, mul_neg_in;
   logic [slr_pkg::PULSE_BITS-1:0]   p0_ff, p0_in;
   logic [slr_pkg::PULSE_BITS-1:0]   pulse_ff, pulse_in;
   logic                             div_go_ff, div_go_in;
   logic [slr_pkg::DIV_NUM_BITS-1:0] div_num_ff, div_num_in;
   logic                             div_neg_ff, div_neg_in;
   logic [slr_pkg::DIV_DEN_BITS-1:0] div_den_ff, div_den_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   slr_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   slr_pkg::div_req_type div_req;
   slr_pkg::div_rsp_type div_rsp;

   logic                           out_free;
   logic                           req_take;
   logic [slr_pkg::TIME_BITS-1:0]  now_t;
   logic [slr_pkg::TIME_BITS-1:0]  progress;
   logic [slr_pkg::ANGLE_BITS-1:0] tgt_sat;
   logic [slr_pkg::ANGLE_BITS-1:0] csr_ang_sat;
   logic [slr_pkg::PULSE_BITS:0]   diff;
   logic [slr_pkg::PULSE_BITS:0]   delta;
   logic [slr_pkg::PULSE_BITS:0]   pulse_sum;
   logic [slr_pkg::PULSE_BITS-1:0] mul_a;
   logic [slr_pkg::DIV_NUM_BITS-1:0] mul_prod;

   // output register frees when empty or being drained this cycle
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = reset || (state_ff != slr_pkg::ST_IDLE) || !out_free;
   assign req_take  = req_valid && !req_stall;

   assign now_t    = slr_pkg::TIME_BITS'(req_word.now_ms);
   assign progress = now_t - start_time_ff;
   assign tgt_sat  = (req_word.target_angle > slr_pkg::FULL_ANGLE) ?
                     slr_pkg::FULL_ANGLE : req_word.target_angle;
   assign csr_ang_sat = (csr_wdata[7:0] > slr_pkg::FULL_ANGLE) ?
                        slr_pkg::FULL_ANGLE : csr_wdata[7:0];

   // pulse span of the angle map; may run downward
   assign diff = {1'b0, max_ff} - {1'b0, min_ff};

   // shared multiplier: angle or progress times a 16 bit magnitude
   always_comb begin
      case (state_ff)
         slr_pkg::ST_P0_MUL: mul_a = {8'd0, cur_ff};
         slr_pkg::ST_P1_MUL: mul_a = {8'd0, goal_ff};
         default:            mul_a = prog_ff;
      endcase
   end
   assign mul_prod = mul_a * mul_mag_ff;

   // base plus signed quotient, wraps to 16 bits
   assign pulse_sum = {1'b0, min_ff} + div_rsp.quotient;
   assign delta     = {1'b0, pulse_sum[slr_pkg::PULSE_BITS-1:0]} - {1'b0, p0_ff};

   always_comb begin
      min_in        = min_ff;
      max_in        = max_ff;
      cur_in        = cur_ff;
      goal_in       = goal_ff;
      start_time_in = start_time_ff;
      span_in       = span_ff;
      waiting_in    = waiting_ff;
      state_in      = state_ff;
      prog_in       = prog_ff;
      mul_mag_in    = mul_mag_ff;
      mul_neg_in    = mul_neg_ff;
      p0_in         = p0_ff;
      pulse_in      = pulse_ff;
      div_go_in     = 1'b0;
      div_num_in    = div_num_ff;
      div_neg_in    = div_neg_ff;
      div_den_in    = div_den_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_word_in   = rsp_word_ff;

      case (state_ff)
         slr_pkg::ST_IDLE: begin
            if (req_take) begin
               // default answer: command style, no pulse
               rsp_valid_in          = 1'b1;
               rsp_word_in.pulse_valid = 1'b0;
               rsp_word_in.pulse_us    = '0;
               rsp_word_in.done_res    = 1'b0;
               rsp_word_in.angle_now   = cur_ff;
               case (req_word.operation)
                  slr_pkg::OP_MOVE: begin
                     start_time_in = now_t;
                     goal_in       = tgt_sat;
                     span_in       = req_word.duration_ms;
                     waiting_in    = 1'b0;
                  end
                  slr_pkg::OP_WAIT: begin
                     start_time_in = now_t;
                     goal_in       = cur_ff;
                     span_in       = req_word.duration_ms;
                     waiting_in    = 1'b1;
                  end
                  slr_pkg::OP_UPDATE: begin
                     if (progress > slr_pkg::TIME_BITS'(span_ff)) begin
                        // period over: settle on the goal
                        cur_in                = goal_ff;
                        waiting_in            = 1'b0;
                        rsp_word_in.done_res  = 1'b1;
                        rsp_word_in.angle_now = goal_ff;
                     end else if (!waiting_ff) begin
                        // ramp running: compute the pulse
                        rsp_valid_in = 1'b0;
                        prog_in      = progress[slr_pkg::SPAN_BITS-1:0];
                        mul_neg_in   = diff[slr_pkg::PULSE_BITS];
                        mul_mag_in   = diff[slr_pkg::PULSE_BITS] ?
                                       slr_pkg::PULSE_BITS'(~diff + 1'b1) :
                                       diff[slr_pkg::PULSE_BITS-1:0];
                        state_in     = slr_pkg::ST_P0_MUL;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         slr_pkg::ST_P0_MUL, slr_pkg::ST_P1_MUL: begin
            div_go_in  = 1'b1;
            div_num_in = mul_prod;
            div_neg_in = mul_neg_ff;
            div_den_in = {8'd0, slr_pkg::FULL_ANGLE};
            state_in   = (state_ff == slr_pkg::ST_P0_MUL) ?
                         slr_pkg::ST_P0_DIV : slr_pkg::ST_P1_DIV;
         end
         slr_pkg::ST_P0_DIV: begin
            if (div_rsp.done) begin
               p0_in    = pulse_sum[slr_pkg::PULSE_BITS-1:0];
               state_in = slr_pkg::ST_P1_MUL;
            end
         end
         slr_pkg::ST_P1_DIV: begin
            if (div_rsp.done) begin
               mul_neg_in = delta[slr_pkg::PULSE_BITS];
               mul_mag_in = delta[slr_pkg::PULSE_BITS] ?
                            slr_pkg::PULSE_BITS'(~delta + 1'b1) :
                            delta[slr_pkg::PULSE_BITS-1:0];
               if (span_ff == '0) begin
                  // zero span: start pulse
                  pulse_in = p0_ff;
                  state_in = slr_pkg::ST_FIN;
               end else begin
                  state_in = slr_pkg::ST_D_MUL;
               end
            end
         end
         slr_pkg::ST_D_MUL: begin
            div_go_in  = 1'b1;
            div_num_in = mul_prod;
            div_neg_in = mul_neg_ff;
            div_den_in = span_ff;
            state_in   = slr_pkg::ST_D_DIV;
         end
         slr_pkg::ST_D_DIV: begin
            if (div_rsp.done) begin
               // interpolation term added on the start pulse
               pulse_in = p0_ff + div_rsp.quotient[slr_pkg::PULSE_BITS-1:0];
               state_in = slr_pkg::ST_FIN;
            end
         end
         slr_pkg::ST_FIN: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_word_in.pulse_valid = 1'b1;
               rsp_word_in.pulse_us    = pulse_ff;
               rsp_word_in.done_res    = 1'b0;
               rsp_word_in.angle_now   = cur_ff;
               state_in                = slr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = slr_pkg::ST_IDLE;
         end
      endcase

      // register writes are for the user to make only while idle; the block itself does not enforce it
      if (csr_we) begin
         case (csr_index)
            slr_pkg::CSR_MIN_PULSE:   min_in = csr_wdata;
            slr_pkg::CSR_MAX_PULSE:   max_in = csr_wdata;
            slr_pkg::CSR_START_ANGLE: begin
               cur_in  = csr_ang_sat;
               goal_in = csr_ang_sat;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= slr_pkg::ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         div_go_ff     <= 1'b0;
         min_ff        <= slr_pkg::MIN_PULSE_RST;
         max_ff        <= slr_pkg::MAX_PULSE_RST;
         cur_ff        <= slr_pkg::START_ANG_RST;
         goal_ff       <= slr_pkg::START_ANG_RST;
         start_time_ff <= '0;
         span_ff       <= '0;
         waiting_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         div_go_ff     <= div_go_in;
         min_ff        <= min_in;
         max_ff        <= max_in;
         cur_ff        <= cur_in;
         goal_ff       <= goal_in;
         start_time_ff <= start_time_in;
         span_ff       <= span_in;
         waiting_ff    <= waiting_in;
      end
   end

   always_ff @(posedge clock) begin
      prog_ff     <= prog_in;
      mul_mag_ff  <= mul_mag_in;
      mul_neg_ff  <= mul_neg_in;
      p0_ff       <= p0_in;
      pulse_ff    <= pulse_in;
      div_num_ff  <= div_num_in;
      div_neg_ff  <= div_neg_in;
      div_den_ff  <= div_den_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign div_req.start    = div_go_ff;
   assign div_req.negate   = div_neg_ff;
   assign div_req.dividend = div_num_ff;
   assign div_req.divisor  = div_den_ff;

   slr_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

// ----- rtl/core/slr_checker.sv -----
// ----------------------------------------------------------------------------
// slr_checker: port level checks for the servo linear ramp
// Watches the top level ports only; attached by bind.
// ----------------------------------------------------------------------------
module slr_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input slr_pkg::req_word_type req_word,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input slr_pkg::rsp_word_type rsp_word
);

   // a held result word stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("result word changed while stalled");

   // a pulse and a period end never come together
   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_word.pulse_valid && rsp_word.done_res))
      else $error("pulse and done in one word");

   // no pulse written means a zero width
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.pulse_valid |-> rsp_word.pulse_us == '0)
      else $error("nonzero pulse width without pulse");

   // commands answer in the next cycle with no pulse and no done
   a_cmd: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_word.operation != slr_pkg::OP_UPDATE)
      |=> rsp_valid && !rsp_word.pulse_valid && !rsp_word.done_res)
      else $error("command answer missing or wrong");

   // stored angle stays in range
   a_angle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word.angle_now <= slr_pkg::FULL_ANGLE)
      else $error("angle out of range");

endmodule

bind servo_linear_ramp_top slr_checker u_slr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_word  (req_word),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for servo_linear_ramp_top
// A negedge driver feeds request words from a planned queue, with random
// gaps, and makes the register writes while the block is quiet. A posedge
// monitor runs an in-bench ramp predictor on every accepted request and
// compares every accepted response word with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

   localparam logic [1:0] OP_SPARE   = 2'd3;   // unused opcode, block ignores it
   localparam logic [1:0] CSR_UNUSED = 2'd3;   // no register behind this index

   localparam int SETTLE_CYCLES = 8;      // quiet cycles before a register write
   localparam int WATCH_LIMIT   = 3000;   // cycles with no handshake at all
   localparam int TAIL_CYCLES   = 100;    // drain time after the last answer
   localparam int END_LIMIT     = 2000000;
   localparam int REPORT_MAX    = 10;
   localparam int PHASE_WORDS   = 230;

   typedef enum logic [1:0] {
      ENT_WORD,   // request word for the block
      ENT_CSR,    // register write, done only when the block is quiet
      ENT_HOLD    // sender pauses until every answer is back
   } entry_kind_type;

   typedef struct packed {
      entry_kind_type        kind;
      slr_pkg::req_word_type word;
      logic [1:0]            idx;
      logic [15:0]           data;
   } entry_type;

   // ------------------------------------------------------------------------
   // clock, reset and block ports; every input has a known value at time 0
   // ------------------------------------------------------------------------
   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   slr_pkg::req_word_type req_word  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   slr_pkg::rsp_word_type rsp_word;
   logic                  csr_we    = 1'b0;
   logic [1:0]            csr_index = '0;
   logic [15:0]           csr_wdata = '0;

   always #5 clock = ~clock;

   servo_linear_ramp_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // ------------------------------------------------------------------------
   // bench state
   // ------------------------------------------------------------------------
   entry_type             send_plan[$];      // planned words, writes and pauses
   slr_pkg::rsp_word_type pulse_answers[$];  // predicted response words, oldest first

   logic req_fire   = 1'b0;   // request word taken at the last rising edge
   logic rsp_fire   = 1'b0;   // response word taken at the last rising edge
   logic calm       = 1'b0;   // both sides run without idling while set
   logic stim_done  = 1'b0;   // plan exhausted and nothing on the request bus
   int   send_gap   = 0;
   int   rsp_wait   = 0;
   int   quiet_cnt  = 0;
   int   idle_cycles = 0;
   int   bad_count  = 0;

   // planning cursor: time stamp and the last command the plan issued
   logic [31:0] gen_now   = '0;
   logic [31:0] gen_start = '0;
   logic [15:0] gen_span  = '0;

   // ------------------------------------------------------------------------
   // ramp predictor: registers and ramp state as they should be in the block
   // ------------------------------------------------------------------------
   logic [15:0] cfg_min   = slr_pkg::MIN_PULSE_RST;
   logic [15:0] cfg_max   = slr_pkg::MAX_PULSE_RST;
   logic [7:0]  cur_ang   = slr_pkg::START_ANG_RST;
   logic [7:0]  goal_ang  = slr_pkg::START_ANG_RST;
   logic [31:0] t0        = '0;
   logic [15:0] span      = '0;
   logic        held      = 1'b0;   // a wait is running

   function automatic logic [7:0] clip_angle(logic [7:0] a);
      return (a > slr_pkg::FULL_ANGLE) ? slr_pkg::FULL_ANGLE : a;
   endfunction

   // signed product, divide truncates toward zero; max below min runs downward
   function automatic longint pulse_of_angle(logic [7:0] a);
      longint lo, diff;
      lo   = longint'(cfg_min);
      diff = longint'(cfg_max) - lo;
      return lo + (longint'(a) * diff) / 180;
   endfunction

   function automatic slr_pkg::rsp_word_type ramp_step(slr_pkg::req_word_type w);
      slr_pkg::rsp_word_type r;
      logic [31:0]           progress;
      longint                p0, p1, p;
      r = '0;
      case (w.operation)
         slr_pkg::OP_MOVE: begin
            t0       = w.now_ms;
            goal_ang = clip_angle(w.target_angle);
            span     = w.duration_ms;
            held     = 1'b0;
         end
         slr_pkg::OP_WAIT: begin
            t0       = w.now_ms;
            goal_ang = cur_ang;
            span     = w.duration_ms;
            held     = 1'b1;
         end
         slr_pkg::OP_UPDATE: begin
            progress = w.now_ms - t0;   // wraps modulo 2^32
            if (progress <= {16'd0, span}) begin
               if (!held) begin
                  p0 = pulse_of_angle(cur_ang);
                  p1 = pulse_of_angle(goal_ang);
                  p  = p0;
                  // zero span: start pulse, no divide
                  if (span != 0)
                     p = p0 + (longint'(progress) * (p1 - p0)) / longint'(span);
                  r.pulse_valid = 1'b1;
                  r.pulse_us    = p[15:0];
               end
            end else begin
               // period over: goal becomes the current angle
               cur_ang     = goal_ang;
               held        = 1'b0;
               r.done_res  = 1'b1;
            end
         end
         default: ;   // spare opcode: no state change
      endcase
      r.angle_now = cur_ang;
      return r;
   endfunction

   function automatic void load_reg(logic [1:0] idx, logic [15:0] v);
      case (idx)
         slr_pkg::CSR_MIN_PULSE:   cfg_min = v;
         slr_pkg::CSR_MAX_PULSE:   cfg_max = v;
         slr_pkg::CSR_START_ANGLE: begin
            // start angle write also reloads current and goal, saturated
            cur_ang   = clip_angle(v[7:0]);
            goal_ang  = cur_ang;
         end
         default: ;
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // plan builders
   // ------------------------------------------------------------------------
   task automatic plan_word(logic [1:0] op, logic [31:0] now, logic [7:0] tgt,
                            logic [15:0] dur);
      entry_type e;
      e = '0;
      e.kind              = ENT_WORD;
      e.word.operation    = op;
      e.word.now_ms       = now;
      e.word.target_angle = tgt;
      e.word.duration_ms  = dur;
      send_plan.push_back(e);
   endtask

   task automatic plan_csr(logic [1:0] idx, logic [15:0] data);
      entry_type e;
      e = '0;
      e.kind = ENT_CSR;
      e.idx  = idx;
      e.data = data;
      send_plan.push_back(e);
   endtask

   task automatic plan_hold();
      entry_type e;
      e = '0;
      e.kind = ENT_HOLD;
      send_plan.push_back(e);
   endtask

   // update at a time stamp placed around the last command's span
   task automatic plan_update();
      logic [31:0] prog;
      case ($urandom_range(0, 9))
         0:       prog = {16'd0, gen_span};
         1:       prog = {16'd0, gen_span} + 32'd1;
         2:       prog = $urandom();
         3:       prog = '0;
         default: prog = $urandom_range(0, gen_span);
      endcase
      plan_word(slr_pkg::OP_UPDATE, gen_start + prog, 8'($urandom_range(0, 255)),
                16'($urandom_range(0, 65535)));
   endtask

   // mostly command-then-updates sequences, some stray updates and noise
   task automatic plan_traffic(int n);
      int          made, k, pick;
      logic [1:0]  op;
      logic [7:0]  tgt;
      logic [15:0] dur;
      logic [31:0] now;
      made = 0;
      while (made < n) begin
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            case ($urandom_range(0, 15))
               0:       gen_now = $urandom();
               1:       gen_now = 32'hFFFF_FFFF - $urandom_range(0, 3000);
               default: gen_now = gen_now + $urandom_range(0, 5000);
            endcase
            case ($urandom_range(0, 9))
               0:       dur = '0;
               1:       dur = 16'hFFFF;
               2:       dur = 16'($urandom_range(0, 65535));
               default: dur = 16'($urandom_range(1, 400));
            endcase
            if ($urandom_range(0, 6) == 0)
               tgt = 8'($urandom_range(0, 255));
            else
               tgt = 8'($urandom_range(0, 180));
            plan_word((pick < 45) ? slr_pkg::OP_MOVE : slr_pkg::OP_WAIT, gen_now, tgt, dur);
            gen_start = gen_now;
            gen_span  = dur;
            made++;
            k = (pick < 45) ? $urandom_range(1, 6) : $urandom_range(1, 3);
            repeat (k) begin
               plan_update();
               made++;
            end
         end else if (pick < 80) begin
            plan_update();
            made++;
         end else if (pick < 94) begin
            // noise: any opcode, fields anywhere
            op  = 2'($urandom_range(0, 3));
            now = $urandom();
            tgt = 8'($urandom_range(0, 255));
            dur = 16'($urandom_range(0, 65535));
            plan_word(op, now, tgt, dur);
            if (op == slr_pkg::OP_MOVE || op == slr_pkg::OP_WAIT) begin
               gen_start = now;
               gen_span  = dur;
            end
            if (op != OP_SPARE)
               made++;
         end else begin
            plan_hold();
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // driver: request words, register writes and pauses at the falling edge
   // ------------------------------------------------------------------------
   always @(negedge clock) begin : drive_side
      logic                  nv;
      slr_pkg::req_word_type nw;
      logic                  we;
      logic [1:0]            ci;
      logic [15:0]           cd;
      entry_type             head;
      nv = req_valid;
      nw = req_word;
      we = 1'b0;
      ci = csr_index;
      cd = csr_wdata;
      if (!reset) begin
         if (req_fire) begin
            nv       = 1'b0;
            send_gap = calm ? 0 : $urandom_range(0, 9);
         end
         // quiet: no word on the bus and no answer outstanding
         if (!nv && pulse_answers.size() == 0)
            quiet_cnt++;
         else
            quiet_cnt = 0;
         if (!nv && send_plan.size() > 0) begin
            if (send_plan[0].kind == ENT_WORD) begin
               if (send_gap > 0) begin
                  send_gap--;
               end else begin
                  head = send_plan.pop_front();
                  nw   = head.word;
                  nv   = 1'b1;
               end
            end else if (quiet_cnt >= SETTLE_CYCLES) begin
               head = send_plan.pop_front();
               if (head.kind == ENT_CSR) begin
                  we = 1'b1;
                  ci = head.idx;
                  cd = head.data;
                  load_reg(head.idx, head.data);
               end
               quiet_cnt = 0;
            end
         end
         stim_done <= (send_plan.size() == 0) && !nv;
      end
      req_valid <= nv;
      req_word  <= nw;
      csr_we    <= we;
      csr_index <= ci;
      csr_wdata <= cd;
   end

   // receiver: a random stall count drawn per response word
   always @(negedge clock) begin : take_side
      if (rsp_fire)
         rsp_wait = calm ? 0 : $urandom_range(0, 9);
      else if (rsp_wait > 0)
         rsp_wait--;
      rsp_stall <= (rsp_wait != 0);
   end

   // ------------------------------------------------------------------------
   // monitor: predict on request handshake, check on response handshake
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : watch_side
      slr_pkg::rsp_word_type want;
      req_fire <= req_valid && !req_stall && !reset;
      rsp_fire <= rsp_valid && !rsp_stall && !reset;
      if (!reset) begin
         // check first: an answer can never belong to a word taken this edge
         if (rsp_valid && !rsp_stall) begin
            if (pulse_answers.size() == 0) begin
               if (bad_count < REPORT_MAX)
                  $display("unexpected rsp word: valid=%0d pulse=%0d done=%0d angle=%0d",
                           rsp_word.pulse_valid, rsp_word.pulse_us,
                           rsp_word.done_res, rsp_word.angle_now);
               bad_count++;
            end else begin
               want = pulse_answers.pop_front();
               if (rsp_word.pulse_valid !== want.pulse_valid ||
                   rsp_word.pulse_us !== want.pulse_us ||
                   rsp_word.done_res !== want.done_res ||
                   rsp_word.angle_now !== want.angle_now) begin
                  if (bad_count < REPORT_MAX)
                     $display("rsp mismatch: expected valid=%0d pulse=%0d done=%0d angle=%0d",
                              want.pulse_valid, want.pulse_us, want.done_res,
                              want.angle_now);
                  if (bad_count < REPORT_MAX)
                     $display("              actual   valid=%0d pulse=%0d done=%0d angle=%0d",
                              rsp_word.pulse_valid, rsp_word.pulse_us,
                              rsp_word.done_res, rsp_word.angle_now);
                  bad_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            pulse_answers.push_back(ramp_step(req_word));
            // now and then switch between idling and back-to-back stretches
            if ($urandom_range(0, 99) == 0)
               calm <= !calm;
         end
      end
   end

   // watchdog: no handshake of any kind for too long ends the run
   always @(posedge clock) begin : stall_watch
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCH_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // plan the whole run, release reset, wait for the drain, report
   // ------------------------------------------------------------------------
   initial begin : run_plan
      int spin;

      // directed part at reset register values
      plan_word(slr_pkg::OP_UPDATE, 32'd0, 8'd0, 16'd0);     // zero span at reset
      plan_word(slr_pkg::OP_MOVE, 32'd1000, 8'd180, 16'd100);
      plan_word(slr_pkg::OP_UPDATE, 32'd1000, 8'd0, 16'd0);  // ramp start
      plan_word(slr_pkg::OP_UPDATE, 32'd1033, 8'd0, 16'd0);
      plan_word(slr_pkg::OP_UPDATE, 32'd1100, 8'd0, 16'd0);  // progress equals span
      plan_word(slr_pkg::OP_UPDATE, 32'd1101, 8'd0, 16'd0);  // just past: done
      plan_word(slr_pkg::OP_UPDATE, 32'd1200, 8'd0, 16'd0);  // done again
      plan_word(slr_pkg::OP_MOVE, 32'd2000, 8'd255, 16'd0);  // target saturates
      plan_word(slr_pkg::OP_UPDATE, 32'd2000, 8'd0, 16'd0);  // zero span, start pulse
      plan_word(slr_pkg::OP_UPDATE, 32'd2001, 8'd0, 16'd0);
      plan_word(slr_pkg::OP_WAIT, 32'd3000, 8'd17, 16'd50);
      plan_word(slr_pkg::OP_UPDATE, 32'd3025, 8'd0, 16'd0);  // holding, no pulse
      plan_word(slr_pkg::OP_UPDATE, 32'd3050, 8'd0, 16'd0);
      plan_word(slr_pkg::OP_UPDATE, 32'd3051, 8'd0, 16'd0);  // wait over
      plan_word(OP_SPARE, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF);
      plan_word(slr_pkg::OP_MOVE, 32'hFFFF_FF00, 8'd0, 16'hFFFF); // ramp across the wrap
      plan_word(slr_pkg::OP_UPDATE, 32'h0000_0100, 8'd0, 16'd0);
      plan_word(slr_pkg::OP_UPDATE, 32'h0000_FEFF, 8'd0, 16'd0);  // longest span, at end
      plan_word(slr_pkg::OP_UPDATE, 32'hFFFF_FEFF, 8'd0, 16'd0);  // before start: done
      plan_word(slr_pkg::OP_MOVE, 32'hFFFF_FFFF, 8'd90, 16'd1);
      plan_word(slr_pkg::OP_UPDATE, 32'h0000_0000, 8'hFF, 16'hFFFF);
      plan_word(slr_pkg::OP_UPDATE, 32'h0000_0002, 8'd0, 16'd0);
      plan_hold();

      // widest mapping, start angle above range
      plan_csr(slr_pkg::CSR_MIN_PULSE, 16'h0000);
      plan_csr(slr_pkg::CSR_MAX_PULSE, 16'hFFFF);
      plan_csr(slr_pkg::CSR_START_ANGLE, 16'hFFFF);
      plan_traffic(PHASE_WORDS);

      // mapping runs downward, start at zero
      plan_csr(slr_pkg::CSR_MIN_PULSE, 16'hFFFF);
      plan_csr(slr_pkg::CSR_MAX_PULSE, 16'h0000);
      plan_csr(slr_pkg::CSR_START_ANGLE, 16'h0000);
      plan_csr(CSR_UNUSED, 16'($urandom_range(0, 65535)));
      plan_traffic(PHASE_WORDS);

      // nominal pulses, full angle with junk in the upper data bits
      plan_csr(slr_pkg::CSR_MIN_PULSE, 16'd500);
      plan_csr(slr_pkg::CSR_MAX_PULSE, 16'd2500);
      plan_csr(slr_pkg::CSR_START_ANGLE, 16'h5AB4);
      plan_traffic(PHASE_WORDS);

      plan_csr(slr_pkg::CSR_MIN_PULSE, 16'($urandom_range(0, 65535)));
      plan_csr(slr_pkg::CSR_MAX_PULSE, 16'($urandom_range(0, 65535)));
      plan_csr(slr_pkg::CSR_START_ANGLE, 16'($urandom_range(0, 65535)));
      plan_traffic(PHASE_WORDS);

      // flat mapping
      plan_csr(slr_pkg::CSR_MIN_PULSE, 16'd1000);
      plan_csr(slr_pkg::CSR_MAX_PULSE, 16'd1000);
      plan_csr(slr_pkg::CSR_START_ANGLE, 16'($urandom_range(0, 255)));
      plan_traffic(PHASE_WORDS);

      plan_csr(slr_pkg::CSR_MIN_PULSE, 16'($urandom_range(0, 3000)));
      plan_csr(slr_pkg::CSR_MAX_PULSE, 16'($urandom_range(0, 65535)));
      plan_csr(slr_pkg::CSR_START_ANGLE, 16'($urandom_range(0, 180)));
      plan_traffic(PHASE_WORDS);

      // synchronous reset, released at a falling edge
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      spin = 0;
      while (!(stim_done && pulse_answers.size() == 0) && spin < END_LIMIT) begin
         @(negedge clock);
         spin++;
      end
      // stray extra answers would show up here
      repeat (TAIL_CYCLES) @(negedge clock);

      if (bad_count == 0 && stim_done && pulse_answers.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
